/* rtl/mds_pkg.sv */
`default_nettype none

package mds_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FIELD_W        = 32;
    localparam int MASK_W         = 9;
    localparam int BSEL_W         = 4;
    localparam int MBR_W          = 8;
    localparam int IN_TDATA_W     = 32;
    localparam int OUT_TDATA_W    = 168;
    localparam int SHL_AMT        = 8;
    localparam int PC_STEP        = 1;

    // b bus sources
    localparam logic [BSEL_W-1:0] BSEL_MDR  = 4'd0;
    localparam logic [BSEL_W-1:0] BSEL_PC   = 4'd1;
    localparam logic [BSEL_W-1:0] BSEL_MBRS = 4'd2;
    localparam logic [BSEL_W-1:0] BSEL_MBRU = 4'd3;
    localparam logic [BSEL_W-1:0] BSEL_SP   = 4'd4;
    localparam logic [BSEL_W-1:0] BSEL_LV   = 4'd5;
    localparam logic [BSEL_W-1:0] BSEL_CPP  = 4'd6;
    localparam logic [BSEL_W-1:0] BSEL_TOS  = 4'd7;

    // c bus write mask bits
    localparam int WR_MAR = 0;
    localparam int WR_MDR = 1;
    localparam int WR_PC  = 2;
    localparam int WR_SP  = 3;
    localparam int WR_LV  = 4;
    localparam int WR_CPP = 5;
    localparam int WR_TOS = 6;
    localparam int WR_OPC = 7;
    localparam int WR_H   = 8;

    // alu function, f0 f1
    localparam logic [1:0] ALU_AND  = 2'b00;
    localparam logic [1:0] ALU_OR   = 2'b01;
    localparam logic [1:0] ALU_NOTB = 2'b10;
    localparam logic [1:0] ALU_ADD  = 2'b11;

    typedef struct packed {
        logic       shift_left8;
        logic       shift_right1;
        logic [1:0] func;
        logic       enable_a;
        logic       enable_b;
        logic       invert_a;
        logic       carry_in;
    } alu_ctrl_t;

endpackage

`default_nettype wire

/* rtl/mds_alu.sv */
`default_nettype none

module mds_alu #(
    parameter int DATA_WIDTH = mds_pkg::DATA_WIDTH_DEF
) (
    input  wire mds_pkg::alu_ctrl_t ctrl,
    input  wire [DATA_WIDTH-1:0]    a_bus,
    input  wire [DATA_WIDTH-1:0]    b_bus,
    output logic [DATA_WIDTH-1:0]   alu_result,
    output logic                    carry_out,
    output logic [DATA_WIDTH-1:0]   shifter_out
);
    import mds_pkg::*;

    logic [DATA_WIDTH-1:0] a_op;
    logic [DATA_WIDTH-1:0] b_op;
    logic [DATA_WIDTH:0]   sum;

    always_comb
    begin
        a_op = (ctrl.enable_a ? a_bus : '0) ^ {DATA_WIDTH{ctrl.invert_a}};
        b_op = ctrl.enable_b ? b_bus : '0;
        sum  = {1'b0, a_op} + {1'b0, b_op} + {{DATA_WIDTH{1'b0}}, ctrl.carry_in};
    end

    always_comb
    begin
        carry_out = 1'b0;
        unique case (ctrl.func)
            ALU_AND:  alu_result = a_op & b_op;
            ALU_OR:   alu_result = a_op | b_op;
            ALU_NOTB: alu_result = ~b_op;
            ALU_ADD:
            begin
                alu_result = sum[DATA_WIDTH-1:0];
                carry_out  = sum[DATA_WIDTH];
            end
            default:  alu_result = '0;
        endcase
    end

    // right shift wins over left shift
    always_comb
    begin
        if (ctrl.shift_right1)
        begin
            shifter_out = {alu_result[DATA_WIDTH-1], alu_result[DATA_WIDTH-1:1]};
        end
        else if (ctrl.shift_left8)
        begin
            shifter_out = alu_result << SHL_AMT;
        end
        else
        begin
            shifter_out = alu_result;
        end
    end

endmodule

`default_nettype wire

/* rtl/microinstruction_datapath_step_top.sv */
// channel  dir  tdata bits  fields (low to high)
// s_axis   in   32          control bits, c_write_mask, b_select, mbr_value
// m_axis   out  168         pc_value, a_bus, b_bus, alu_result, carry_out,
//                           shifter_out, negative, zero
//
// one microinstruction per cycle while m_tready does not stall the result
// the single-cycle path is the b mux, the full-width adder and the shifter
// all datapath registers reset to zero, pc counts from zero
// an input register and a result register part the two sides; a stalled
// result still lets one more transaction into an empty input register
`default_nettype none

module microinstruction_datapath_step_top #(
    parameter int DATA_WIDTH = mds_pkg::DATA_WIDTH_DEF
) (
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               s_tvalid,
    output logic                              s_tready,
    // shift_left8, shift_right1, func_hi, func_lo, enable_a, enable_b,
    // invert_a, carry_in, c_write_mask[8:0], b_select[3:0], mbr_value[7:0]
    input  wire [mds_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  wire                               m_tready,
    // pc_value, a_bus, b_bus, alu_result, carry_out, shifter_out, negative, zero
    output logic [mds_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import mds_pkg::*;

    logic                   in_valid_reg;
    logic [IN_TDATA_W-1:0]  in_data_reg;
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic [OUT_TDATA_W-1:0] out_data_next;

    logic [DATA_WIDTH-1:0] h_reg;
    logic [DATA_WIDTH-1:0] opc_reg;
    logic [DATA_WIDTH-1:0] tos_reg;
    logic [DATA_WIDTH-1:0] cpp_reg;
    logic [DATA_WIDTH-1:0] lv_reg;
    logic [DATA_WIDTH-1:0] sp_reg;
    logic [DATA_WIDTH-1:0] pc_reg;
    logic [DATA_WIDTH-1:0] mdr_reg;
    logic [DATA_WIDTH-1:0] mar_reg;
    logic [DATA_WIDTH-1:0] pc_next;

    logic                  advance;
    alu_ctrl_t             ctrl;
    logic [MASK_W-1:0]     wmask;
    logic [BSEL_W-1:0]     bsel;
    logic [MBR_W-1:0]      mbr;
    logic [DATA_WIDTH-1:0] b_bus;
    logic [DATA_WIDTH-1:0] alu_result;
    logic                  carry_out;
    logic [DATA_WIDTH-1:0] shifter_out;
    logic                  negative;
    logic                  zero;

    logic [FIELD_W-1:0] pc_f;
    logic [FIELD_W-1:0] a_f;
    logic [FIELD_W-1:0] b_f;
    logic [FIELD_W-1:0] alu_f;
    logic [FIELD_W-1:0] sh_f;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb
    begin
        ctrl.shift_left8  = in_data_reg[0];
        ctrl.shift_right1 = in_data_reg[1];
        ctrl.func         = {in_data_reg[2], in_data_reg[3]};
        ctrl.enable_a     = in_data_reg[4];
        ctrl.enable_b     = in_data_reg[5];
        ctrl.invert_a     = in_data_reg[6];
        ctrl.carry_in     = in_data_reg[7];
        wmask             = in_data_reg[16:8];
        bsel              = in_data_reg[20:17];
        mbr               = in_data_reg[28:21];
    end

    always_comb
    begin
        unique case (bsel)
            BSEL_MDR:  b_bus = mdr_reg;
            BSEL_PC:   b_bus = pc_reg;
            BSEL_MBRS: b_bus = {{(DATA_WIDTH-MBR_W){mbr[MBR_W-1]}}, mbr};
            BSEL_MBRU: b_bus = {{(DATA_WIDTH-MBR_W){1'b0}}, mbr};
            BSEL_SP:   b_bus = sp_reg;
            BSEL_LV:   b_bus = lv_reg;
            BSEL_CPP:  b_bus = cpp_reg;
            BSEL_TOS:  b_bus = tos_reg;
            default:   b_bus = opc_reg;
        endcase
    end

    mds_alu #(
        .DATA_WIDTH (DATA_WIDTH)
    ) u_alu (
        .ctrl        (ctrl),
        .a_bus       (h_reg),
        .b_bus       (b_bus),
        .alu_result  (alu_result),
        .carry_out   (carry_out),
        .shifter_out (shifter_out)
    );

    assign negative = shifter_out[DATA_WIDTH-1];
    assign zero     = (shifter_out == '0);
    assign pc_next  = (wmask[WR_PC] ? shifter_out : pc_reg)
                      + DATA_WIDTH'(PC_STEP);

    generate
        if (DATA_WIDTH >= FIELD_W)
        begin : g_trunc
            assign pc_f  = pc_reg[FIELD_W-1:0];
            assign a_f   = h_reg[FIELD_W-1:0];
            assign b_f   = b_bus[FIELD_W-1:0];
            assign alu_f = alu_result[FIELD_W-1:0];
            assign sh_f  = shifter_out[FIELD_W-1:0];
        end
        else
        begin : g_ext
            assign pc_f  = {{(FIELD_W-DATA_WIDTH){1'b0}}, pc_reg};
            assign a_f   = {{(FIELD_W-DATA_WIDTH){1'b0}}, h_reg};
            assign b_f   = {{(FIELD_W-DATA_WIDTH){1'b0}}, b_bus};
            assign alu_f = {{(FIELD_W-DATA_WIDTH){1'b0}}, alu_result};
            assign sh_f  = {{(FIELD_W-DATA_WIDTH){1'b0}}, shifter_out};
        end
    endgenerate

    assign out_data_next = {5'b0, zero, negative, sh_f, carry_out, alu_f, b_f, a_f, pc_f};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= s_tdata;
        end
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_reg   <= '0;
            opc_reg <= '0;
            tos_reg <= '0;
            cpp_reg <= '0;
            lv_reg  <= '0;
            sp_reg  <= '0;
            pc_reg  <= '0;
            mdr_reg <= '0;
            mar_reg <= '0;
        end
        else if (advance)
        begin
            if (wmask[WR_H])   h_reg   <= shifter_out;
            if (wmask[WR_OPC]) opc_reg <= shifter_out;
            if (wmask[WR_TOS]) tos_reg <= shifter_out;
            if (wmask[WR_CPP]) cpp_reg <= shifter_out;
            if (wmask[WR_LV])  lv_reg  <= shifter_out;
            if (wmask[WR_SP])  sp_reg  <= shifter_out;
            if (wmask[WR_MDR]) mdr_reg <= shifter_out;
            if (wmask[WR_MAR]) mar_reg <= shifter_out;
            pc_reg <= pc_next;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result lost after step");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance && !wmask[WR_PC] |=> pc_reg == $past(pc_reg) + DATA_WIDTH'(PC_STEP))
        else $error("pc did not step");

    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(h_reg) && $stable(pc_reg) && $stable(mar_reg))
        else $error("state changed without a step");

    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !advance |-> !s_tready)
        else $error("input register overrun");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> !(zero && negative))
        else $error("flags inconsistent");
`endif

endmodule

`default_nettype wire
